// ===== rtl/ccne_pkg.sv =====
// ----------------------------------------------------------------------------
// ccne_pkg: shared types and constants of the click-count number entry core
// Request and result structs, operation and phase codes, register indexes.
// ----------------------------------------------------------------------------
package ccne_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned TickW   = 16;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLICK = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    PH_WAIT0  = 3'd0,
    PH_BLINK  = 3'd1,
    PH_WAIT1  = 3'd2,
    PH_BUZZ   = 3'd3,
    PH_REPORT = 3'd4,
    PH_IDLE   = 3'd5
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICKS_PER_SECOND = 3'd0,
    CFG_BLINK_LEVEL      = 3'd1,
    CFG_BUZZ_LEVEL_HIGH  = 3'd2,
    CFG_BUZZ_LEVEL_LOW   = 3'd3,
    CFG_FLASH_LEVEL      = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    KIND_LEVEL = 1'b0,
    KIND_VALUE = 1'b1
  } kind_e;

  // Blink period position codes (low five bits of the tick count)
  localparam logic [4:0] BlinkOnPos  = 5'd10;
  localparam logic [4:0] BlinkOffPos = 5'd20;
  localparam logic [4:0] BlinkEndPos = 5'd31;

  localparam logic [1:0] BuzzHighPos = 2'd0;
  localparam logic [1:0] BuzzLowPos  = 2'd2;

  localparam logic [7:0] TpsReset       = 8'd62;
  localparam logic [7:0] BlinkLvlReset  = 8'd37;
  localparam logic [7:0] BuzzHighReset  = 8'd25;
  localparam logic [7:0] BuzzLowReset   = 8'd18;
  localparam logic [7:0] FlashLvlReset  = 8'd75;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] option_number;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] led_level;
    logic [7:0] entered_value;
    logic       last;
  } res_t;

  function automatic res_t mk_res(kind_e kind, logic [7:0] level, logic [7:0] value);
    res_t r;
    r.kind          = kind;
    r.led_level     = level;
    r.entered_value = value;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/click_count_number_entry_core.sv =====
// ----------------------------------------------------------------------------
// click_count_number_entry_core: one-button number entry sequencer
// Blinks an option number, buzzes while counting clicks, reports the count.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid_i / in_stall_o with a req_t payload (start,
//   tick or click). Each request updates the sequencer state in the cycle it
//   is accepted and yields zero, one or two LED commands or a final value on
//   out_valid_o / out_stall_i as res_t items; last marks the final one.
//   Results appear in the cycle after the request is accepted.
//   Throughput: one request per cycle while each gives at most one result
//   and the receiver keeps up; a request with two results holds the input
//   until the two-entry result queue, draining one item per cycle while
//   the receiver keeps up, is popping its second item.
//   Receiver stall: the queue holds its contents and in_stall_o stays high
//   until the queue is empty after the current pop.
//   Reset: sequencer idle, click count and tick counter cleared, result
//   queue empty, registers at their defaults. The user writes registers
//   through cfg_we_i / cfg_idx_i / cfg_wdata_i while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module click_count_number_entry_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ccne_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ccne_pkg::LevelW-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ccne_pkg::req_t                 in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ccne_pkg::res_t                 out_res_o
);
  import ccne_pkg::*;

  logic [7:0] tps_q, blink_lvl_q, buzz_hi_q, buzz_lo_q, flash_lvl_q;

  phase_e           phase_q, phase_d;
  logic [7:0]       clicks_q, clicks_d;
  logic [7:0]       blinks_q, blinks_d;
  logic [TickW-1:0] tick_q, tick_d;

  logic [1:0] count_q, count_d;
  res_t       head_q, head_d, tail_q, tail_d;

  logic       pop, accept;
  logic [1:0] count_left;
  logic [1:0] n_res;
  res_t       r0, r1;
  op_e        op;

  logic [TickW-1:0] tick_inc;
  logic             wait_done;
  logic [9:0]       tps_x3;
  logic             timeout;
  logic [4:0]       blink_pos;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q       <= TpsReset;
      blink_lvl_q <= BlinkLvlReset;
      buzz_hi_q   <= BuzzHighReset;
      buzz_lo_q   <= BuzzLowReset;
      flash_lvl_q <= FlashLvlReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TICKS_PER_SECOND: tps_q       <= cfg_wdata_i;
        CFG_BLINK_LEVEL:      blink_lvl_q <= cfg_wdata_i;
        CFG_BUZZ_LEVEL_HIGH:  buzz_hi_q   <= cfg_wdata_i;
        CFG_BUZZ_LEVEL_LOW:   buzz_lo_q   <= cfg_wdata_i;
        CFG_FLASH_LEVEL:      flash_lvl_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  assign pop        = out_valid_o && !out_stall_i;
  assign count_left = count_q - {1'b0, pop};
  assign in_stall_o = (count_left != 2'd0);
  assign accept     = in_valid_i && !in_stall_o;
  assign op         = op_e'(in_req_i.op);

  // ---------------------------------------------------------------- shared terms
  assign tick_inc  = tick_q + TickW'(1);
  assign wait_done = !(tick_q < {{(TickW-7){1'b0}}, tps_q[7:1]});
  assign tps_x3    = {2'b00, tps_q} + {1'b0, tps_q, 1'b0};
  assign timeout   = tick_inc > {{(TickW-10){1'b0}}, tps_x3};
  assign blink_pos = tick_q[4:0];

  // ---------------------------------------------------------------- next state
  always_comb begin
    phase_d  = phase_q;
    clicks_d = clicks_q;
    blinks_d = blinks_q;
    tick_d   = tick_q;
    unique case (op)
      OP_START: begin
        clicks_d = '0;
        blinks_d = in_req_i.option_number;
        phase_d  = PH_WAIT0;
        tick_d   = '0;
      end
      OP_TICK: begin
        unique case (phase_q)
          PH_WAIT0, PH_WAIT1: begin
            if (!wait_done) begin
              tick_d = tick_inc;
            end else begin
              phase_d = (phase_q == PH_WAIT0) ? PH_BLINK : PH_BUZZ;
              tick_d  = '0;
            end
          end
          PH_BLINK: begin
            if (blinks_q != 8'd0) begin
              if (blink_pos == BlinkEndPos) blinks_d = blinks_q - 8'd1;
              tick_d = tick_inc;
            end else begin
              phase_d = PH_WAIT1;
              tick_d  = '0;
            end
          end
          PH_BUZZ: begin
            tick_d = tick_inc;
            if (timeout) phase_d = PH_REPORT;
          end
          PH_REPORT: phase_d = PH_IDLE;
          default: ;
        endcase
      end
      OP_CLICK: begin
        if (phase_q == PH_BUZZ) begin
          clicks_d = clicks_q + 8'd1;
          tick_d   = '0;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- results
  always_comb begin
    n_res = 2'd0;
    r0    = mk_res(KIND_LEVEL, '0, '0);
    r1    = mk_res(KIND_LEVEL, '0, '0);
    unique case (op)
      OP_TICK: begin
        unique case (phase_q)
          PH_BLINK: begin
            if (blinks_q != 8'd0) begin
              if (blink_pos == BlinkOnPos) begin
                r0    = mk_res(KIND_LEVEL, blink_lvl_q, '0);
                n_res = 2'd1;
              end else if (blink_pos == BlinkOffPos) begin
                n_res = 2'd1;
              end
            end
          end
          PH_BUZZ: begin
            if (tick_inc[1:0] == BuzzHighPos) begin
              r0    = mk_res(KIND_LEVEL, buzz_hi_q, '0);
              n_res = 2'd1;
            end else if (tick_inc[1:0] == BuzzLowPos) begin
              r0    = mk_res(KIND_LEVEL, buzz_lo_q, '0);
              n_res = 2'd1;
            end
            // timeout turns the LED off after any buzz level
            if (timeout) n_res = n_res + 2'd1;
          end
          PH_REPORT: begin
            r0    = mk_res(KIND_VALUE, '0, clicks_q);
            n_res = 2'd1;
          end
          default: ;
        endcase
      end
      OP_CLICK: begin
        if (phase_q == PH_BUZZ) begin
          r0    = mk_res(KIND_LEVEL, flash_lvl_q, '0);
          n_res = 2'd2;
        end
      end
      default: ;
    endcase
    if (n_res == 2'd1) r0.last = 1'b1;
    if (n_res == 2'd2) r1.last = 1'b1;
  end

  // ---------------------------------------------------------------- result queue
  always_comb begin
    count_d = count_left;
    head_d  = pop ? tail_q : head_q;
    tail_d  = tail_q;
    if (accept && n_res != 2'd0) begin
      count_d = n_res;
      head_d  = r0;
      tail_d  = r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      clicks_q <= '0;
      blinks_q <= '0;
      tick_q   <= '0;
      count_q  <= '0;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        clicks_q <= clicks_d;
        blinks_q <= blinks_d;
        tick_q   <= tick_d;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign out_valid_o = (count_q != 2'd0);
  assign out_res_o   = head_q;

endmodule

// ===== rtl/ccne_checker.sv =====
// ----------------------------------------------------------------------------
// ccne_checker: port-level checks for the click-count number entry core
// Watches the channels over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ccne_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input ccne_pkg::res_t out_res_o
);
  import ccne_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  // a pending second result blocks new requests
  a_pair_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.last |-> in_stall_o)
    else $error("request accepted while result pair pending");

  // the final value closes its request
  a_value_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.kind |-> out_res_o.last && out_res_o.led_level == '0)
    else $error("value result malformed");

  a_level_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.kind |-> out_res_o.entered_value == '0)
    else $error("level result carries a value");

  // an empty queue never stalls the input
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty queue");

endmodule

bind click_count_number_entry_core ccne_checker u_ccne_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);
